### design/svp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svp_pkg
// Constants, tables and widths shared by the space-vector PWM modulator.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_STEPS   = 30;
    localparam int ROOT_STEPS     = 32;
    localparam int DIV_STEPS      = 32;

    localparam int ATAN_W = 49;   // atan2 vector datapath
    localparam int SIN_W  = 34;   // sine rotation datapath

    localparam logic [15:0] SUPPLY_RESET = 16'd3072;

    localparam logic signed [SIN_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [31:0]      SQRT3_Q30       = 32'sd1859775393;
    localparam logic [31:0]             QUARTER_TURN    = 32'h4000_0000;
    localparam logic [31:0]             HALF_TURN       = 32'h8000_0000;
    localparam logic signed [63:0]      ONE_Q32         = 64'sh1_0000_0000;

    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // floor((s+1) * 2^32 / 6): end of sector s, in turn units
    function automatic logic [32:0] sector_end(input logic [2:0] s);
        logic [32:0] v;
        case (s)
            3'd0:    v = 33'd715827882;
            3'd1:    v = 33'd1431655765;
            3'd2:    v = 33'd2147483648;
            3'd3:    v = 33'd2863311530;
            3'd4:    v = 33'd3579139413;
            3'd5:    v = 33'd4294967296;
            default: v = 33'd0;
        endcase
        return v;
    endfunction

    // ceil(s * 2^32 / 6): start of sector s, in turn units
    function automatic logic [31:0] sector_start(input logic [2:0] s);
        logic [31:0] v;
        case (s)
            3'd0:    v = 32'd0;
            3'd1:    v = 32'd715827883;
            3'd2:    v = 32'd1431655766;
            3'd3:    v = 32'd2147483648;
            3'd4:    v = 32'd2863311531;
            3'd5:    v = 32'd3579139414;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### design/space_vector_pwm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// space_vector_pwm
// Six-sector space-vector PWM modulator: dq voltage and angle in, three
// centered duties, the sector and a saturation flag out.
// ----------------------------------------------------------------------------
// Use: present i_volt_q, i_volt_d and i_elec_angle with i_valid; a request is
// taken on a clock edge where i_valid is high and o_stall is low. Results
// leave on o_valid and are taken when i_stall is low. i_cfg_we writes the
// supply voltage (Q8.8, zero acts as one); write it only while idle.
// The datapath is a fully pipelined chain: a 32-stage square root beside
// a 30-stage atan2 CORDIC, then a 32-stage restoring divider beside two
// 30-stage sine CORDICs, then four multiply and sum stages and the output
// register. One request is taken every cycle while the output is not stalled.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the supply register with 12 V.
// ----------------------------------------------------------------------------
module space_vector_pwm #(
    parameter int ANGLE_BITS = svp_pkg::ANGLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_volt_q,
    input  wire logic signed [15:0] i_volt_d,
    input  wire logic [15:0]        i_elec_angle,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_duty_a,
    output logic [15:0]             o_duty_b,
    output logic [15:0]             o_duty_c,
    output logic [2:0]              o_sector_num,
    output logic                    o_clipped
);

    localparam int AW   = svp_pkg::ATAN_W;
    localparam int SW   = svp_pkg::SIN_W;
    localparam int NR   = svp_pkg::ROOT_STEPS;
    localparam int ND   = svp_pkg::DIV_STEPS;
    localparam int NC   = svp_pkg::CORDIC_STEPS;
    localparam int DROP = 32 - ANGLE_BITS;
    localparam logic [31:0] ANGLE_MASK = {{ANGLE_BITS{1'b1}}, {DROP{1'b0}}};

    logic r_out_valid;
    logic w_adv;
    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    // supply register
    logic [15:0] r_supply;
    logic [15:0] w_divisor;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= svp_pkg::SUPPLY_RESET;
        end else if (i_cfg_we) begin
            r_supply <= i_cfg_data;
        end
    end
    assign w_divisor = (r_supply == 16'd0) ? 16'd1 : r_supply;

    // ---------------- entry register
    logic               r_s0_valid;
    logic signed [15:0] r_s0_q;
    logic signed [15:0] r_s0_d;
    logic [15:0]        r_s0_ang;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_q   <= i_volt_q;
            r_s0_d   <= i_volt_d;
            r_s0_ang <= i_elec_angle;
        end
    end

    // ---------------- phase 1: square root and atan2
    logic                  r1_valid [0:NR];
    logic [63:0]           r1_rem   [0:NR];
    logic [63:0]           r1_root  [0:NR];
    logic signed [AW-1:0]  r1_x     [0:NR];
    logic signed [AW-1:0]  r1_y     [0:NR];
    logic [31:0]           r1_z     [0:NR];
    logic [15:0]           r1_ang   [0:NR];
    logic                  r1_dzero [0:NR];
    logic                  r1_qneg  [0:NR];
    logic [15:0]           r1_qabs  [0:NR];

    logic [63:0]           n1_rem   [0:NR];
    logic [63:0]           n1_root  [0:NR];
    logic signed [AW-1:0]  n1_x     [0:NR];
    logic signed [AW-1:0]  n1_y     [0:NR];
    logic [31:0]           n1_z     [0:NR];

    logic signed [31:0] w_qq;
    logic signed [31:0] w_dd;
    logic [32:0]        w_r2;
    logic signed [16:0] w_nq;
    logic signed [16:0] w_nd;
    logic signed [16:0] w_qabs;

    always_comb begin
        w_qq   = r_s0_q * r_s0_q;
        w_dd   = r_s0_d * r_s0_d;
        w_r2   = {1'b0, w_qq} + {1'b0, w_dd};
        w_qabs = r_s0_q[15] ? -17'(r_s0_q) : 17'(r_s0_q);
        // fold a negative d axis into the right half plane
        w_nq   = r_s0_d[15] ? -17'(r_s0_q) : 17'(r_s0_q);
        w_nd   = r_s0_d[15] ? -17'(r_s0_d) : 17'(r_s0_d);
        n1_rem[0]  = {w_r2[31:0], 32'd0};
        n1_root[0] = 64'd0;
        n1_x[0]    = {{(AW-47){w_nd[16]}}, w_nd, 30'd0};
        n1_y[0]    = {{(AW-47){w_nq[16]}}, w_nq, 30'd0};
        n1_z[0]    = r_s0_d[15] ? svp_pkg::HALF_TURN : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r1_valid[0] <= r_s0_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_rem[0]   <= n1_rem[0];
            r1_root[0]  <= n1_root[0];
            r1_x[0]     <= n1_x[0];
            r1_y[0]     <= n1_y[0];
            r1_z[0]     <= n1_z[0];
            r1_ang[0]   <= r_s0_ang;
            r1_dzero[0] <= (r_s0_d == 16'sd0);
            r1_qneg[0]  <= r_s0_q[15];
            r1_qabs[0]  <= w_qabs[15:0];
        end
    end

    for (genvar i = 0; i < NR; i++) begin : g_ph1
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] w_try;
        always_comb begin
            w_try = r1_root[i] + BIT;
            if (r1_rem[i] >= w_try) begin
                n1_rem[i+1]  = r1_rem[i] - w_try;
                n1_root[i+1] = (r1_root[i] >> 1) + BIT;
            end else begin
                n1_rem[i+1]  = r1_rem[i];
                n1_root[i+1] = r1_root[i] >> 1;
            end
        end
        if (i < NC) begin : g_atan
            always_comb begin
                if (r1_y[i] > 0) begin
                    n1_x[i+1] = r1_x[i] + (r1_y[i] >>> i);
                    n1_y[i+1] = r1_y[i] - (r1_x[i] >>> i);
                    n1_z[i+1] = r1_z[i] + svp_pkg::ATAN_TURNS[i];
                end else begin
                    n1_x[i+1] = r1_x[i] - (r1_y[i] >>> i);
                    n1_y[i+1] = r1_y[i] + (r1_x[i] >>> i);
                    n1_z[i+1] = r1_z[i] - svp_pkg::ATAN_TURNS[i];
                end
            end
        end else begin : g_hold
            always_comb begin
                n1_x[i+1] = r1_x[i];
                n1_y[i+1] = r1_y[i];
                n1_z[i+1] = r1_z[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r1_valid[i+1] <= 1'b0;
            end else if (w_adv) begin
                r1_valid[i+1] <= r1_valid[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r1_rem[i+1]   <= n1_rem[i+1];
                r1_root[i+1]  <= n1_root[i+1];
                r1_x[i+1]     <= n1_x[i+1];
                r1_y[i+1]     <= n1_y[i+1];
                r1_z[i+1]     <= n1_z[i+1];
                r1_ang[i+1]   <= r1_ang[i];
                r1_dzero[i+1] <= r1_dzero[i];
                r1_qneg[i+1]  <= r1_qneg[i];
                r1_qabs[i+1]  <= r1_qabs[i];
            end
        end
    end

    // ---------------- adjusted angle and dividend
    logic        r_p1_valid;
    logic [31:0] r_p1_w;
    logic [31:0] r_p1_dvd;
    logic        r_p1_neg;
    logic [31:0] n_p1_w;
    logic [31:0] n_p1_dvd;
    logic [31:0] w_offset;

    always_comb begin
        w_offset = r1_dzero[NR] ? svp_pkg::QUARTER_TURN : r1_z[NR];
        n_p1_w   = ({r1_ang[NR], 16'd0} + w_offset) & ANGLE_MASK;
        n_p1_dvd = r1_dzero[NR] ? {r1_qabs[NR], 16'd0} : r1_root[NR][31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_adv) begin
            r_p1_valid <= r1_valid[NR];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_w   <= n_p1_w;
            r_p1_dvd <= n_p1_dvd;
            r_p1_neg <= r1_dzero[NR] && r1_qneg[NR];
        end
    end

    // ---------------- phase 2: divider and two sine rotations
    logic                 r2_valid [0:ND];
    logic [31:0]          r2_dvd   [0:ND];
    logic [15:0]          r2_rem   [0:ND];
    logic [31:0]          r2_quot  [0:ND];
    logic signed [SW-1:0] r2_ax    [0:ND];
    logic signed [SW-1:0] r2_ay    [0:ND];
    logic signed [SW-1:0] r2_az    [0:ND];
    logic signed [SW-1:0] r2_bx    [0:ND];
    logic signed [SW-1:0] r2_by    [0:ND];
    logic signed [SW-1:0] r2_bz    [0:ND];
    logic [2:0]           r2_sec   [0:ND];
    logic                 r2_neg   [0:ND];

    logic [15:0]          n2_rem   [1:ND];
    logic [31:0]          n2_quot  [1:ND];
    logic signed [SW-1:0] n2_ax    [1:ND];
    logic signed [SW-1:0] n2_ay    [1:ND];
    logic signed [SW-1:0] n2_az    [1:ND];
    logic signed [SW-1:0] n2_bx    [1:ND];
    logic signed [SW-1:0] n2_by    [1:ND];
    logic signed [SW-1:0] n2_bz    [1:ND];

    logic [34:0] w_w6;
    logic [2:0]  w_sidx;
    logic [32:0] w_arg1;
    logic [31:0] w_arg2;

    always_comb begin
        w_w6   = {1'b0, r_p1_w, 2'b00} + {2'b00, r_p1_w, 1'b0};
        w_sidx = w_w6[34:32];
        w_arg1 = svp_pkg::sector_end(w_sidx) - {1'b0, r_p1_w};
        w_arg2 = r_p1_w - svp_pkg::sector_start(w_sidx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r2_valid[0] <= r_p1_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_dvd[0]  <= r_p1_dvd;
            r2_rem[0]  <= 16'd0;
            r2_quot[0] <= 32'd0;
            r2_ax[0]   <= svp_pkg::CORDIC_GAIN_Q30;
            r2_ay[0]   <= '0;
            r2_az[0]   <= {1'b0, w_arg1};
            r2_bx[0]   <= svp_pkg::CORDIC_GAIN_Q30;
            r2_by[0]   <= '0;
            r2_bz[0]   <= {2'b00, w_arg2};
            r2_sec[0]  <= w_sidx + 3'd1;
            r2_neg[0]  <= r_p1_neg;
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_ph2
        logic [16:0] w_sh;
        always_comb begin
            w_sh = {r2_rem[j], r2_dvd[j][31-j]};
            if (w_sh >= {1'b0, w_divisor}) begin
                n2_rem[j+1]  = 16'(w_sh - {1'b0, w_divisor});
                n2_quot[j+1] = {r2_quot[j][30:0], 1'b1};
            end else begin
                n2_rem[j+1]  = w_sh[15:0];
                n2_quot[j+1] = {r2_quot[j][30:0], 1'b0};
            end
        end
        if (j < NC) begin : g_sin
            localparam logic signed [SW-1:0] ANG =
                $signed({{(SW-32){1'b0}}, svp_pkg::ATAN_TURNS[j]});
            always_comb begin
                if (r2_az[j] >= 0) begin
                    n2_ax[j+1] = r2_ax[j] - (r2_ay[j] >>> j);
                    n2_ay[j+1] = r2_ay[j] + (r2_ax[j] >>> j);
                    n2_az[j+1] = r2_az[j] - ANG;
                end else begin
                    n2_ax[j+1] = r2_ax[j] + (r2_ay[j] >>> j);
                    n2_ay[j+1] = r2_ay[j] - (r2_ax[j] >>> j);
                    n2_az[j+1] = r2_az[j] + ANG;
                end
                if (r2_bz[j] >= 0) begin
                    n2_bx[j+1] = r2_bx[j] - (r2_by[j] >>> j);
                    n2_by[j+1] = r2_by[j] + (r2_bx[j] >>> j);
                    n2_bz[j+1] = r2_bz[j] - ANG;
                end else begin
                    n2_bx[j+1] = r2_bx[j] + (r2_by[j] >>> j);
                    n2_by[j+1] = r2_by[j] - (r2_bx[j] >>> j);
                    n2_bz[j+1] = r2_bz[j] + ANG;
                end
            end
        end else begin : g_hold
            always_comb begin
                n2_ax[j+1] = r2_ax[j];
                n2_ay[j+1] = r2_ay[j];
                n2_az[j+1] = r2_az[j];
                n2_bx[j+1] = r2_bx[j];
                n2_by[j+1] = r2_by[j];
                n2_bz[j+1] = r2_bz[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r2_valid[j+1] <= 1'b0;
            end else if (w_adv) begin
                r2_valid[j+1] <= r2_valid[j];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r2_dvd[j+1]  <= r2_dvd[j];
                r2_rem[j+1]  <= n2_rem[j+1];
                r2_quot[j+1] <= n2_quot[j+1];
                r2_ax[j+1]   <= n2_ax[j+1];
                r2_ay[j+1]   <= n2_ay[j+1];
                r2_az[j+1]   <= n2_az[j+1];
                r2_bx[j+1]   <= n2_bx[j+1];
                r2_by[j+1]   <= n2_by[j+1];
                r2_bz[j+1]   <= n2_bz[j+1];
                r2_sec[j+1]  <= r2_sec[j];
                r2_neg[j+1]  <= r2_neg[j];
            end
        end
    end

    // ---------------- M1: magnitude sign, sqrt(3) * sin
    logic                 r_m1_valid;
    logic signed [33:0]   r_m1_m;
    logic signed [65:0]   r_m1_p1;
    logic signed [65:0]   r_m1_p2;
    logic [2:0]           r_m1_sec;
    logic signed [33:0]   n_m1_m;

    assign n_m1_m = r2_neg[ND] ? -$signed({2'b00, r2_quot[ND]})
                               :  $signed({2'b00, r2_quot[ND]});

    // ---------------- M2: t = m * k
    logic                 r_m2_valid;
    logic signed [66:0]   r_m2_p1;
    logic signed [66:0]   r_m2_p2;
    logic [2:0]           r_m2_sec;
    logic signed [32:0]   w_k1;
    logic signed [32:0]   w_k2;

    assign w_k1 = $signed(r_m1_p1[62:30]);
    assign w_k2 = $signed(r_m1_p2[62:30]);

    // ---------------- M3: t1, t2, half of t0
    logic                 r_m3_valid;
    logic signed [63:0]   r_m3_t1;
    logic signed [63:0]   r_m3_t2;
    logic signed [63:0]   r_m3_h;
    logic [2:0]           r_m3_sec;
    logic signed [63:0]   n_m3_t1;
    logic signed [63:0]   n_m3_t2;
    logic signed [63:0]   w_t0;

    always_comb begin
        n_m3_t1 = $signed({{11{r_m2_p1[66]}}, r_m2_p1[66:14]});
        n_m3_t2 = $signed({{11{r_m2_p2[66]}}, r_m2_p2[66:14]});
        w_t0    = svp_pkg::ONE_Q32 - n_m3_t1 - n_m3_t2;
    end

    // ---------------- M4: sector table
    logic                 r_m4_valid;
    logic signed [63:0]   r_m4_ta;
    logic signed [63:0]   r_m4_tb;
    logic signed [63:0]   r_m4_tc;
    logic [2:0]           r_m4_sec;
    logic signed [63:0]   n_m4_ta;
    logic signed [63:0]   n_m4_tb;
    logic signed [63:0]   n_m4_tc;
    logic signed [63:0]   w_t1h;
    logic signed [63:0]   w_t2h;
    logic signed [63:0]   w_all;

    always_comb begin
        w_t1h = r_m3_t1 + r_m3_h;
        w_t2h = r_m3_t2 + r_m3_h;
        w_all = w_t1h + r_m3_t2;
        case (r_m3_sec)
            svp_pkg::SECTOR_1: begin
                n_m4_ta = w_all;  n_m4_tb = w_t2h;  n_m4_tc = r_m3_h;
            end
            svp_pkg::SECTOR_2: begin
                n_m4_ta = w_t1h;  n_m4_tb = w_all;  n_m4_tc = r_m3_h;
            end
            svp_pkg::SECTOR_3: begin
                n_m4_ta = r_m3_h; n_m4_tb = w_all;  n_m4_tc = w_t2h;
            end
            svp_pkg::SECTOR_4: begin
                n_m4_ta = r_m3_h; n_m4_tb = w_t1h;  n_m4_tc = w_all;
            end
            svp_pkg::SECTOR_5: begin
                n_m4_ta = w_t2h;  n_m4_tb = r_m3_h; n_m4_tc = w_all;
            end
            default: begin
                n_m4_ta = w_all;  n_m4_tb = r_m3_h; n_m4_tc = w_t1h;
            end
        endcase
    end

    // ---------------- output register with saturation
    logic [15:0] r_out_a;
    logic [15:0] r_out_b;
    logic [15:0] r_out_c;
    logic [2:0]  r_out_sec;
    logic        r_out_clip;
    logic [15:0] n_out_a;
    logic [15:0] n_out_b;
    logic [15:0] n_out_c;
    logic [2:0]  w_clip;

    always_comb begin
        if (r_m4_ta < 0) begin
            n_out_a = 16'd0;      w_clip[0] = 1'b1;
        end else if (r_m4_ta[63:32] != 32'd0) begin
            n_out_a = 16'hFFFF;   w_clip[0] = 1'b1;
        end else begin
            n_out_a = r_m4_ta[31:16]; w_clip[0] = 1'b0;
        end
        if (r_m4_tb < 0) begin
            n_out_b = 16'd0;      w_clip[1] = 1'b1;
        end else if (r_m4_tb[63:32] != 32'd0) begin
            n_out_b = 16'hFFFF;   w_clip[1] = 1'b1;
        end else begin
            n_out_b = r_m4_tb[31:16]; w_clip[1] = 1'b0;
        end
        if (r_m4_tc < 0) begin
            n_out_c = 16'd0;      w_clip[2] = 1'b1;
        end else if (r_m4_tc[63:32] != 32'd0) begin
            n_out_c = 16'hFFFF;   w_clip[2] = 1'b1;
        end else begin
            n_out_c = r_m4_tc[31:16]; w_clip[2] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid  <= 1'b0;
            r_m2_valid  <= 1'b0;
            r_m3_valid  <= 1'b0;
            r_m4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_m1_valid  <= r2_valid[ND];
            r_m2_valid  <= r_m1_valid;
            r_m3_valid  <= r_m2_valid;
            r_m4_valid  <= r_m3_valid;
            r_out_valid <= r_m4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_m     <= n_m1_m;
            r_m1_p1    <= svp_pkg::SQRT3_Q30 * r2_ay[ND];
            r_m1_p2    <= svp_pkg::SQRT3_Q30 * r2_by[ND];
            r_m1_sec   <= r2_sec[ND];
            r_m2_p1    <= r_m1_m * w_k1;
            r_m2_p2    <= r_m1_m * w_k2;
            r_m2_sec   <= r_m1_sec;
            r_m3_t1    <= n_m3_t1;
            r_m3_t2    <= n_m3_t2;
            r_m3_h     <= w_t0 >>> 1;
            r_m3_sec   <= r_m2_sec;
            r_m4_ta    <= n_m4_ta;
            r_m4_tb    <= n_m4_tb;
            r_m4_tc    <= n_m4_tc;
            r_m4_sec   <= r_m3_sec;
            r_out_a    <= n_out_a;
            r_out_b    <= n_out_b;
            r_out_c    <= n_out_c;
            r_out_sec  <= r_m4_sec;
            r_out_clip <= |w_clip;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_duty_a     = r_out_a;
    assign o_duty_b     = r_out_b;
    assign o_duty_c     = r_out_c;
    assign o_sector_num = r_out_sec;
    assign o_clipped    = r_out_clip;

endmodule
`default_nettype wire
